@@ hdl/krs_pkg.sv @@
// shared constants and codes for the keyed record store
package krs_pkg;

	localparam int BUFFER_BYTES_DEF    = 8192;
	localparam int KEY_BYTES_DEF       = 28;
	localparam int MAX_VALUE_BYTES_DEF = 512;

	localparam int KEY_WORD_W  = 56;
	localparam int KEY_IDX_W   = 5;
	localparam int CAP_W       = 14;
	localparam int VLEN_W      = 10;
	localparam int HAVE_W      = 11;

	localparam logic [1:0] CMD_GET = 2'd0;
	localparam logic [1:0] CMD_SET = 2'd1;
	localparam logic [1:0] CMD_DEL = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_WRONG_ARG = 2'd2;
	localparam logic [1:0] ST_NO_SPACE  = 2'd3;

endpackage

@@ hdl/keyed_record_store_top.sv @@
// keyed record store: packed key/value records in a byte memory, byte-serial sequencer
//
// Commands enter on start when busy is low. A set arrives as a stream of items,
// eight value bytes each; items with last_word low leave the block idle and give
// no result. The final set item, a get or a delete then runs the sequencer (bad
// arguments or an unknown command give a wrong-arg result without it), which walks
// the records one memory byte at a time. Removing a record moves every later byte
// down through the memory one byte at a time; appending writes the header and then
// the value bytes; a get reads the value bytes in turn. busy stays high meanwhile.
// Results appear for one cycle each with strobe high and carry last_result on the
// final one of a command; the receiver cannot stall them and they are never held.
// A get gives one result per started group of 8 returned bytes, at least one; all other commands give one result.
// cfg_valid writes the capacity register (cfg_ready is always high); the user must
// do so only while the block is idle: the block does not enforce it. Reset clears
// used length, partial set, capacity (to full buffer), not memory, which needs none.
module keyed_record_store_top #(
	parameter int BUFFER_BYTES    = krs_pkg::BUFFER_BYTES_DEF,
	parameter int KEY_BYTES       = krs_pkg::KEY_BYTES_DEF,
	parameter int MAX_VALUE_BYTES = krs_pkg::MAX_VALUE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [7:0]  key_length,
	input  logic [55:0] key_word_0,
	input  logic [55:0] key_word_1,
	input  logic [55:0] key_word_2,
	input  logic [55:0] key_word_3,
	input  logic [8:0]  occurrence,
	input  logic [9:0]  value_length,
	input  logic [63:0] value_word,
	input  logic        last_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [13:0] cfg_data,
	output logic        strobe,
	output logic [1:0]  status,
	output logic [63:0] data_word,
	output logic [3:0]  valid_bytes,
	output logic [9:0]  stored_length,
	output logic        last_result
);

	localparam int HDR    = KEY_BYTES + 3;
	localparam int AW     = $clog2(BUFFER_BYTES + 1);
	localparam int MA     = $clog2(BUFFER_BYTES);
	localparam int SW     = ((AW > 17) ? AW : 17) + 2;
	localparam int PWORDS = (MAX_VALUE_BYTES + 7) / 8;
	localparam int PA     = (PWORDS > 1) ? $clog2(PWORDS) : 1;
	localparam int PWW    = $clog2(PWORDS + 1);
	localparam int BUFFER_BYTES_CAP = (BUFFER_BYTES < 16383) ? BUFFER_BYTES : 16383;

	typedef enum logic [15:0] {
		S_IDLE  = 16'b0000_0000_0000_0001,
		S_HDR   = 16'b0000_0000_0000_0010,
		S_LEN0  = 16'b0000_0000_0000_0100,
		S_LEN1  = 16'b0000_0000_0000_1000,
		S_KL    = 16'b0000_0000_0001_0000,
		S_KEY   = 16'b0000_0000_0010_0000,
		S_KEYC  = 16'b0000_0000_0100_0000,
		S_MATCH = 16'b0000_0000_1000_0000,
		S_MVR   = 16'b0000_0001_0000_0000,
		S_MVW   = 16'b0000_0010_0000_0000,
		S_GRD   = 16'b0000_0100_0000_0000,
		S_GACC  = 16'b0000_1000_0000_0000,
		S_SPACE = 16'b0001_0000_0000_0000,
		S_APH   = 16'b0010_0000_0000_0000,
		S_APR   = 16'b0100_0000_0000_0000,
		S_APW   = 16'b1000_0000_0000_0000
	} state_t;

	state_t state_q;

	logic [7:0]  mem [BUFFER_BYTES];
	logic [63:0] pend_mem [PWORDS];
	logic [7:0]  mem_rd_q;
	logic [63:0] pend_rd_q;

	logic [1:0]             cmd_q;
	logic [7:0]             klen_q;
	logic [8*KEY_BYTES-1:0] key_q;
	logic [8:0]             occ_q;
	logic [9:0]             vlen_q;
	logic [SW-1:0]          pos_q;
	logic [SW-1:0]          tot_q;
	logic [SW-1:0]          idx_q;
	logic [SW-1:0]          used_q;
	logic [AW-1:0]          cnt_q;
	logic [7:0]             lo_q;
	logic [9:0]             rdl_q;
	logic [63:0]            word_q;
	logic [PWW-1:0]         pw_q;
	logic [krs_pkg::HAVE_W-1:0] have_q;
	logic [krs_pkg::CAP_W-1:0]  cap_q;

	logic        strobe_q, last_q;
	logic [1:0]  status_q;
	logic [63:0] data_q;
	logic [3:0]  vb_q;
	logic [9:0]  sl_q;

	logic [SW-1:0] hdr_w, key_w, cap_eff, p_hdr, p_tot, p_mv, used_hv, stored;
	logic [SW-1:0] len_full, idx_nx;
	logic [MA-1:0] ra, wa;
	logic          we;
	logic [7:0]    wd, hdr_byte, key_byte, pend_byte;
	logic [63:0]   word_nx;
	logic          accept;
	logic [PWW-1:0] pw_inc;
	logic [krs_pkg::HAVE_W-1:0] have_nx;
	logic          key_bad;
	logic [9:0]    rd_len;

	assign hdr_w    = SW'(HDR);
	assign key_w    = SW'(KEY_BYTES);
	assign cap_eff  = (SW'(cap_q) < SW'(BUFFER_BYTES)) ? SW'(cap_q) : SW'(BUFFER_BYTES);
	assign p_hdr    = pos_q + hdr_w;
	assign p_tot    = pos_q + tot_q;
	assign p_mv     = p_tot + idx_q;
	assign used_hv  = used_q + hdr_w + SW'(vlen_q);
	assign stored   = tot_q - hdr_w;
	assign len_full = hdr_w + SW'({mem_rd_q, lo_q});
	assign idx_nx   = idx_q + SW'(1);
	assign key_byte = key_q[8*idx_q[krs_pkg::KEY_IDX_W-1:0] +: 8];
	assign pend_byte = pend_rd_q[8*idx_q[2:0] +: 8];
	assign word_nx  = word_q | (64'(mem_rd_q) << (8*idx_q[2:0]));
	assign accept   = start && !busy;
	assign pw_inc   = (pw_q < PWW'(PWORDS)) ? pw_q + PWW'(1) : pw_q;
	assign have_nx  = (krs_pkg::HAVE_W'(pw_inc) * krs_pkg::HAVE_W'(8)
		< krs_pkg::HAVE_W'(MAX_VALUE_BYTES))
		? krs_pkg::HAVE_W'(pw_inc) * krs_pkg::HAVE_W'(8)
		: krs_pkg::HAVE_W'(MAX_VALUE_BYTES);
	assign key_bad  = key_length > 8'(KEY_BYTES);
	assign rd_len   = (stored < SW'(vlen_q)) ? stored[9:0] : vlen_q;

	always_comb begin
		if (idx_q < key_w) begin
			hdr_byte = (idx_q < SW'(klen_q)) ? key_byte : 8'h00;
		end else if (idx_q == key_w) begin
			hdr_byte = klen_q;
		end else if (idx_q == key_w + SW'(1)) begin
			hdr_byte = vlen_q[7:0];
		end else begin
			hdr_byte = {6'b0, vlen_q[9:8]};
		end
	end

	always_comb begin
		ra = '0;
		we = 1'b0;
		wa = '0;
		wd = mem_rd_q;
		case (state_q)
			S_HDR:  ra = MA'(pos_q + key_w + SW'(1));
			S_LEN0: ra = MA'(pos_q + key_w + SW'(2));
			S_LEN1: ra = MA'(pos_q + key_w);
			S_KEY:  ra = MA'(pos_q + idx_q);
			S_MVR:  ra = MA'(p_mv);
			S_GRD:  ra = MA'(p_hdr + idx_q);
			S_MVW: begin
				we = 1'b1;
				wa = MA'(pos_q + idx_q);
			end
			S_APH: begin
				we = 1'b1;
				wa = MA'(used_q + idx_q);
				wd = hdr_byte;
			end
			S_APW: begin
				we = 1'b1;
				wa = MA'(used_q + hdr_w + idx_q);
				wd = (SW'(have_q) > idx_q) ? pend_byte : 8'h00;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		mem_rd_q <= mem[ra];
		if (accept && command == krs_pkg::CMD_SET && pw_q < PWW'(PWORDS)) begin
			pend_mem[pw_q[PA-1:0]] <= value_word;
		end
		pend_rd_q <= pend_mem[idx_q[PA+2:3]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			used_q   <= '0;
			pw_q     <= '0;
			cap_q    <= krs_pkg::CAP_W'(BUFFER_BYTES_CAP);
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q  <= command;
						klen_q <= key_length;
						key_q  <= (8*KEY_BYTES)'({key_word_3, key_word_2, key_word_1, key_word_0});
						occ_q  <= occurrence;
						vlen_q <= value_length;
						pos_q  <= '0;
						cnt_q  <= '0;
						status_q <= krs_pkg::ST_WRONG_ARG;
						data_q <= '0;
						vb_q   <= '0;
						sl_q   <= '0;
						last_q <= 1'b1;
						if (command == krs_pkg::CMD_SET) begin
							if (!last_word) begin
								pw_q <= pw_inc;
							end else begin
								pw_q   <= '0;
								have_q <= have_nx;
								if (key_bad || value_length > 10'(MAX_VALUE_BYTES)) begin
									strobe_q <= 1'b1;
								end else begin
									state_q <= S_HDR;
								end
							end
						end else begin
							pw_q <= '0;
							if (command != krs_pkg::CMD_GET && command != krs_pkg::CMD_DEL
								|| key_bad) begin
								strobe_q <= 1'b1;
							end else begin
								state_q <= S_HDR;
							end
						end
					end
				end
				S_HDR: begin
					if (p_hdr > used_q || p_hdr > SW'(BUFFER_BYTES)) begin
						// end of the record walk
						if (cmd_q == krs_pkg::CMD_SET) begin
							state_q <= S_SPACE;
						end else begin
							strobe_q <= 1'b1;
							status_q <= krs_pkg::ST_NOT_FOUND;
							state_q  <= S_IDLE;
						end
					end else begin
						state_q <= S_LEN0;
					end
				end
				S_LEN0: begin
					lo_q    <= mem_rd_q;
					state_q <= S_LEN1;
				end
				S_LEN1: begin
					tot_q   <= len_full;
					state_q <= S_KL;
				end
				S_KL: begin
					if (p_tot > used_q) begin
						if (cmd_q == krs_pkg::CMD_SET) begin
							state_q <= S_SPACE;
						end else begin
							strobe_q <= 1'b1;
							status_q <= krs_pkg::ST_NOT_FOUND;
							state_q  <= S_IDLE;
						end
					end else if (mem_rd_q != klen_q) begin
						pos_q   <= p_tot;
						state_q <= S_HDR;
					end else begin
						idx_q   <= '0;
						state_q <= S_KEY;
					end
				end
				S_KEY: begin
					state_q <= (idx_q == SW'(klen_q)) ? S_MATCH : S_KEYC;
				end
				S_KEYC: begin
					if (mem_rd_q != key_byte) begin
						pos_q   <= p_tot;
						state_q <= S_HDR;
					end else begin
						idx_q   <= idx_nx;
						state_q <= S_KEY;
					end
				end
				S_MATCH: begin
					idx_q <= '0;
					if (cmd_q == krs_pkg::CMD_SET) begin
						state_q <= S_MVR;
					end else if (cnt_q == AW'(occ_q)) begin
						if (cmd_q == krs_pkg::CMD_DEL) begin
							state_q <= S_MVR;
						end else begin
							rdl_q  <= rd_len;
							word_q <= '0;
							if (rd_len == '0) begin
								strobe_q <= 1'b1;
								status_q <= krs_pkg::ST_OK;
								sl_q     <= stored[9:0];
								state_q  <= S_IDLE;
							end else begin
								state_q <= S_GRD;
							end
						end
					end else begin
						cnt_q   <= cnt_q + AW'(1);
						pos_q   <= p_tot;
						state_q <= S_HDR;
					end
				end
				S_MVR: begin
					// close the gap one byte at a time
					if (p_mv < used_q) begin
						state_q <= S_MVW;
					end else begin
						used_q <= used_q - tot_q;
						if (cmd_q == krs_pkg::CMD_SET) begin
							state_q <= S_HDR;
						end else begin
							strobe_q <= 1'b1;
							status_q <= krs_pkg::ST_OK;
							state_q  <= S_IDLE;
						end
					end
				end
				S_MVW: begin
					idx_q   <= idx_nx;
					state_q <= S_MVR;
				end
				S_GRD: begin
					state_q <= S_GACC;
				end
				S_GACC: begin
					if (idx_nx == SW'(rdl_q) || idx_q[2:0] == 3'd7) begin
						strobe_q <= 1'b1;
						status_q <= krs_pkg::ST_OK;
						data_q   <= word_nx;
						vb_q     <= 4'(idx_q[2:0]) + 4'd1;
						sl_q     <= stored[9:0];
						last_q   <= idx_nx == SW'(rdl_q);
						word_q   <= '0;
					end else begin
						word_q <= word_nx;
					end
					idx_q   <= idx_nx;
					state_q <= (idx_nx == SW'(rdl_q)) ? S_IDLE : S_GRD;
				end
				S_SPACE: begin
					idx_q <= '0;
					if (used_hv > cap_eff) begin
						strobe_q <= 1'b1;
						status_q <= krs_pkg::ST_NO_SPACE;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_APH;
					end
				end
				S_APH: begin
					if (idx_q == hdr_w - SW'(1)) begin
						idx_q   <= '0;
						state_q <= S_APR;
					end else begin
						idx_q <= idx_nx;
					end
				end
				S_APR: begin
					if (idx_q == SW'(vlen_q)) begin
						used_q   <= used_hv;
						strobe_q <= 1'b1;
						status_q <= krs_pkg::ST_OK;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_APW;
					end
				end
				S_APW: begin
					idx_q   <= idx_nx;
					state_q <= S_APR;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = state_q != S_IDLE;
	assign cfg_ready     = 1'b1;
	assign strobe        = strobe_q;
	assign status        = status_q;
	assign data_word     = data_q;
	assign valid_bytes   = vb_q;
	assign stored_length = sl_q;
	assign last_result   = last_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= SW'(BUFFER_BYTES))
		else $error("used length beyond buffer");

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status != krs_pkg::ST_OK |-> last_result)
		else $error("error result not final");

	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && valid_bytes != 4'd0 |-> status == krs_pkg::ST_OK && valid_bytes <= 4'd8)
		else $error("data on a failed result");

	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("sequencer left idle without a command");

endmodule

@@ bench/tb_keyed_record_store_top.sv @@
// testbench for the keyed record store: predicts each command's results and checks them
module tb_keyed_record_store_top;

	localparam int HDR = krs_pkg::KEY_BYTES_DEF + 3;
	localparam longint CYCLE_LIMIT = 64'd40000000;
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] data_word;
		logic [3:0]  valid_bytes;
		logic [9:0]  stored_length;
		logic        last_result;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  command = krs_pkg::CMD_GET;
	logic [7:0]  key_length = '0;
	logic [55:0] key_word_0 = '0, key_word_1 = '0, key_word_2 = '0, key_word_3 = '0;
	logic [8:0]  occurrence = '0;
	logic [9:0]  value_length = '0;
	logic [63:0] value_word = '0;
	logic        last_word = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [13:0] cfg_data = '0;
	logic        strobe;
	logic [1:0]  status;
	logic [63:0] data_word;
	logic [3:0]  valid_bytes;
	logic [9:0]  stored_length;
	logic        last_result;

	keyed_record_store_top DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predicted store contents
	logic [7:0]  mem [krs_pkg::BUFFER_BYTES_DEF];
	int          used_len;
	logic [7:0]  pend [krs_pkg::MAX_VALUE_BYTES_DEF];
	int          pend_cnt;
	int          cap_bytes;
	result_t     expected_q[$];
	int          errors;
	longint      cycles;

	// four keys of lengths 0, 9, 18 and 27 so that matches happen often
	logic [55:0] key_pool [4][4];
	logic [7:0]  klen_pool [4];

	function automatic int rec_len(int p);
		return int'({mem[p+krs_pkg::KEY_BYTES_DEF+2], mem[p+krs_pkg::KEY_BYTES_DEF+1]});
	endfunction

	function automatic logic [7:0] key_byte(logic [55:0] kw [4], int b);
		return kw[b/7][(b%7)*8 +: 8];
	endfunction

	function automatic bit rec_match(int p, logic [55:0] kw [4], int kl);
		if (mem[p+krs_pkg::KEY_BYTES_DEF] != kl) return 0;
		for (int b = 0; b < kl; b++)
			if (mem[p+b] != key_byte(kw, b)) return 0;
		return 1;
	endfunction

	function automatic int rec_total(int p);
		int t;
		if (p + HDR > used_len) return -1;
		t = HDR + rec_len(p);
		if (p + t > used_len) return -1;
		return t;
	endfunction

	function automatic void cut_record(int p, int n);
		for (int i = p; i + n < used_len; i++) mem[i] = mem[i+n];
		used_len -= n;
	endfunction

	function automatic void push_result(logic [1:0] st, logic [63:0] d, int vb, int sl,
			bit lr);
		result_t r;
		r.status = st; r.data_word = d; r.valid_bytes = 4'(vb);
		r.stored_length = 10'(sl); r.last_result = lr;
		expected_q.push_back(r);
	endfunction

	function automatic void predict_store(logic [1:0] cmd, int kl, logic [55:0] kw [4],
			int occ, int vl, logic [63:0] vw, bit lw);
		int p, t, cnt, stored, rd, n;
		logic [63:0] d;
		if (cmd == krs_pkg::CMD_SET) begin
			for (int b = 0; b < 8; b++)
				if (pend_cnt < krs_pkg::MAX_VALUE_BYTES_DEF) begin
					pend[pend_cnt] = vw[b*8 +: 8];
					pend_cnt++;
				end
			if (!lw) return;
			n = pend_cnt;
			pend_cnt = 0;
			if (kl > krs_pkg::KEY_BYTES_DEF || vl > krs_pkg::MAX_VALUE_BYTES_DEF) begin
				push_result(krs_pkg::ST_WRONG_ARG, 0, 0, 0, 1);
				return;
			end
			p = 0;
			for (t = rec_total(p); t >= 0; t = rec_total(p))
				if (rec_match(p, kw, kl)) cut_record(p, t);
				else p += t;
			if (used_len + HDR + vl > (cap_bytes < krs_pkg::BUFFER_BYTES_DEF ? cap_bytes :
					krs_pkg::BUFFER_BYTES_DEF)) begin
				push_result(krs_pkg::ST_NO_SPACE, 0, 0, 0, 1);
				return;
			end
			p = used_len;
			for (int b = 0; b < krs_pkg::KEY_BYTES_DEF; b++)
				mem[p+b] = b < kl ? key_byte(kw, b) : 8'h0;
			mem[p+krs_pkg::KEY_BYTES_DEF] = 8'(kl);
			mem[p+krs_pkg::KEY_BYTES_DEF+1] = vl[7:0];
			mem[p+krs_pkg::KEY_BYTES_DEF+2] = vl[15:8];
			for (int b = 0; b < vl; b++) mem[p+HDR+b] = b < n ? pend[b] : 8'h0;
			used_len += HDR + vl;
			push_result(krs_pkg::ST_OK, 0, 0, 0, 1);
			return;
		end
		pend_cnt = 0;
		if (cmd == CMD_UNKNOWN || kl > krs_pkg::KEY_BYTES_DEF) begin
			push_result(krs_pkg::ST_WRONG_ARG, 0, 0, 0, 1);
			return;
		end
		p = 0;
		cnt = 0;
		for (t = rec_total(p); t >= 0; t = rec_total(p)) begin
			if (rec_match(p, kw, kl)) begin
				if (cnt == occ) begin
					if (cmd == krs_pkg::CMD_DEL) begin
						cut_record(p, t);
						push_result(krs_pkg::ST_OK, 0, 0, 0, 1);
						return;
					end
					stored = t - HDR;
					rd = stored < vl ? stored : vl;
					if (rd == 0) begin
						push_result(krs_pkg::ST_OK, 0, 0, stored, 1);
						return;
					end
					for (int w = 0; w * 8 < rd; w++) begin
						n = rd - w * 8 > 8 ? 8 : rd - w * 8;
						d = '0;
						for (int b = 0; b < n; b++) d[b*8 +: 8] = mem[p+HDR+w*8+b];
						push_result(krs_pkg::ST_OK, d, n, stored, (w + 1) * 8 >= rd);
					end
					return;
				end
				cnt++;
			end
			p += t;
		end
		push_result(krs_pkg::ST_NOT_FOUND, 0, 0, 0, 1);
	endfunction

	// result checker
	always @(posedge clk) begin
		result_t e;
		if (arst_n && strobe) begin
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: status %0d", status);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (status !== e.status) begin
					$error("status exp %0d got %0d", e.status, status); errors++;
				end
				if (data_word !== e.data_word) begin
					$error("data_word exp %h got %h", e.data_word, data_word); errors++;
				end
				if (valid_bytes !== e.valid_bytes) begin
					$error("valid_bytes exp %0d got %0d", e.valid_bytes, valid_bytes);
					errors++;
				end
				if (stored_length !== e.stored_length) begin
					$error("stored_length exp %0d got %0d", e.stored_length, stored_length);
					errors++;
				end
				if (last_result !== e.last_result) begin
					$error("last_result exp %0d got %0d", e.last_result, last_result);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// start stays high across items sent back to back; it drops only for a gap or a drain
	task automatic send_item(logic [1:0] cmd, int kl, logic [55:0] kw [4], int occ, int vl,
			logic [63:0] vw, bit lw, bit gaps = 1);
		int gap;
		gap = gaps ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command <= cmd; key_length <= 8'(kl);
		key_word_0 <= kw[0]; key_word_1 <= kw[1]; key_word_2 <= kw[2]; key_word_3 <= kw[3];
		occurrence <= 9'(occ); value_length <= 10'(vl); value_word <= vw; last_word <= lw;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_store(cmd, kl, kw, occ, vl, vw, lw);
		@(negedge clk);
	endtask

	// stream a whole set of the given number of words: usually enough for the value, sometimes short or long
	task automatic send_set(int kl, logic [55:0] kw [4], int vl, int words);
		for (int w = 0; w < words; w++)
			send_item(krs_pkg::CMD_SET, kl, kw, $urandom, vl, {$urandom, $urandom},
				w == words - 1);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (2000) @(negedge clk);
	endtask

	task automatic write_capacity(int c);
		wait_drained();
		cfg_data <= 14'(c);
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cap_bytes = c;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void pick_key(output int kl, output logic [55:0] kw [4]);
		int i;
		i = $urandom_range(0, 3);
		kl = klen_pool[i];
		kw = key_pool[i];
	endfunction

	task automatic test_directed();
		logic [55:0] kmax [4], kz [4];
		for (int i = 0; i < 4; i++) begin
			kmax[i] = {56{1'b1}};
			kz[i] = '0;
		end
		send_item(krs_pkg::CMD_GET, 0, kz, 0, 8, 0, 1);
		send_item(krs_pkg::CMD_DEL, 28, kmax, 0, 0, 0, 1);
		send_set(28, kmax, 16, 2);
		send_set(0, kz, 0, 1);
		send_set(28, kmax, 20, 4);
		send_set(28, kmax, 24, 2);
		send_item(krs_pkg::CMD_GET, 28, kmax, 0, 512, 0, 1);
		send_item(krs_pkg::CMD_GET, 28, kmax, 0, 0, 0, 1);
		send_item(krs_pkg::CMD_GET, 28, kmax, 511, 5, 0, 0);
		send_item(krs_pkg::CMD_GET, 0, kz, 0, 8, 0, 1);
		send_set(3, kmax, 512, 64);
		send_set(3, kmax, 40, 70);
		send_item(krs_pkg::CMD_GET, 3, kmax, 0, 512, 0, 1);
		send_set(29, kmax, 8, 1);
		send_set(255, kmax, 8, 1);
		send_set(5, kmax, 1023, 1);
		send_item(CMD_UNKNOWN, 5, kz, 0, 0, 0, 1);
		send_item(krs_pkg::CMD_GET, 255, kz, 0, 0, 0, 1);
		send_item(krs_pkg::CMD_SET, 5, kmax, 0, 8, {64{1'b1}}, 0);
		send_item(krs_pkg::CMD_DEL, 28, kmax, 0, 0, 0, 1);
		send_item(krs_pkg::CMD_DEL, 0, kz, 0, 0, 0, 1);
	endtask

	task automatic test_capacity_limits();
		logic [55:0] kw [4];
		int kl;
		write_capacity(0);
		pick_key(kl, kw);
		send_set(kl, kw, 8, 1);
		write_capacity(40);
		send_set(kl, kw, 8, 1);
		send_set(kl, kw, 9, 2);
		write_capacity(16383);
		send_set(kl, kw, 200, 25);
		write_capacity(krs_pkg::BUFFER_BYTES_DEF);
	endtask

	task automatic test_random_traffic(int n);
		logic [55:0] kw [4];
		int kl, vl, r, words;
		for (int i = 0; i < n; i++) begin
			pick_key(kl, kw);
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0) vl = $urandom_range(0, 512);
			else vl = $urandom_range(0, 40);
			if (r < 45) begin
				words = (vl + 7) / 8;
				if ($urandom_range(0, 5) == 0) words = $urandom_range(1, 6);
				if (words == 0) words = 1;
				send_set(kl, kw, vl, words);
				i += words - 1;
			end else if (r < 75) begin
				send_item(krs_pkg::CMD_GET, kl, kw, $urandom_range(0, 2), vl,
					{$urandom, $urandom}, 1'($urandom));
			end else if (r < 92) begin
				send_item(krs_pkg::CMD_DEL, kl, kw, $urandom_range(0, 2), vl, 0,
					1'($urandom));
			end else if (r < 96) begin
				send_item(krs_pkg::CMD_SET, kl, kw, 0, vl, {$urandom, $urandom}, 0);
			end else begin
				kw[0] = 56'({$urandom, $urandom});
				send_item(2'($urandom_range(0, 3)), $urandom_range(0, 255), kw,
					$urandom_range(0, 511), $urandom_range(0, 1023), 0, 1);
			end
			if (i == n / 2) wait_drained();
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		used_len = 0;
		pend_cnt = 0;
		cap_bytes = krs_pkg::BUFFER_BYTES_DEF;
		for (int i = 0; i < 4; i++) begin
			klen_pool[i] = 8'(i * 9);
			for (int j = 0; j < 4; j++) key_pool[i][j] = 56'({$urandom, $urandom});
		end
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_capacity_limits();
		test_random_traffic(40);
		write_capacity(300);
		test_random_traffic(20);
		write_capacity(krs_pkg::BUFFER_BYTES_DEF);
		test_random_traffic(22);
		wait_drained();
		if (errors == 0 && expected_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			if (expected_q.size() != 0) $error("%0d results never arrived", expected_q.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
